FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/ldf_pkg.sv
`default_nettype none
package ldf_pkg;

   // distance and fog range registers are unsigned q16.8
   localparam int DIST_BITS    = 24;
   // factor is q1.16, one is 2^16
   localparam int FRAC_BITS    = 16;
   localparam int FACTOR_BITS  = FRAC_BITS + 1;
   localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(1) << FRAC_BITS;

   // square root: root bits resolved per stage
   localparam int SQ_STEPS     = 2;
   localparam int SQ_STAGES    = DIST_BITS / SQ_STEPS;
   // division: quotient bits resolved per stage
   localparam int DIV_STEPS    = 2;
   localparam int DIV_STAGES   = FRAC_BITS / DIV_STEPS;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FOG_ENABLE = 3'd0,
      CSR_FOG_START  = 3'd1,
      CSR_FOG_END    = 3'd2,
      CSR_FOG_COLOR  = 3'd3,
      CSR_CAMERA_X   = 3'd4,
      CSR_CAMERA_Y   = 3'd5,
      CSR_CAMERA_Z   = 3'd6
   } csr_idx_type;

   typedef logic [DIST_BITS-1:0]   dist_type;
   typedef logic [FACTOR_BITS-1:0] factor_type;

endpackage
`default_nettype wire

FILE: hdl/ldf_dist.sv
`default_nettype none
module ldf_dist #(
   parameter int COORD_WIDTH = 24,
   parameter int SIDE_WIDTH  = 25
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire  signed [COORD_WIDTH-1:0]       pos_x,
   input  wire  signed [COORD_WIDTH-1:0]       pos_y,
   input  wire  signed [COORD_WIDTH-1:0]       pos_z,
   input  wire  signed [COORD_WIDTH-1:0]       cam_x,
   input  wire  signed [COORD_WIDTH-1:0]       cam_y,
   input  wire  signed [COORD_WIDTH-1:0]       cam_z,
   input  wire         [SIDE_WIDTH-1:0]        in_side,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output ldf_pkg::dist_type                   out_dist,
   output logic                                out_far,
   output logic        [SIDE_WIDTH-1:0]        out_side
);
   import ldf_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int EW  = (DW > DIST_BITS) ? DW : DIST_BITS + 1;
   localparam int SQW = 2 * DIST_BITS;
   localparam int RW  = DIST_BITS + 2;
   localparam int NST = 3 + SQ_STAGES;

   logic                  v_ff    [NST];
   logic [SIDE_WIDTH-1:0] side_ff [NST];
   logic                  far_ff  [NST];
   logic                  rdy     [NST+1];

   logic [DW-1:0]         d_ff    [3];
   logic [SQW-1:0]        sq_ff   [3];

   logic [RW-1:0]         rem_ff  [SQ_STAGES+1];
   logic [DIST_BITS-1:0]  root_ff [SQ_STAGES+1];
   logic [SQW-1:0]        x_ff    [SQ_STAGES+1];

   logic [DW-1:0]         d_in    [3];
   logic [SQW-1:0]        sq_in   [3];
   logic                  far1_in;
   logic [SQW+1:0]        sum_in;
   logic [RW-1:0]         rem_in  [SQ_STAGES];
   logic [DIST_BITS-1:0]  root_in [SQ_STAGES];
   logic [SQW-1:0]        x_in    [SQ_STAGES];

   // ready runs back from the output so bubbles collapse
   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   // absolute component differences
   always_comb begin
      logic signed [DW-1:0] p [3];
      logic signed [DW-1:0] c [3];
      logic signed [DW-1:0] s;
      p[0] = DW'(pos_x); p[1] = DW'(pos_y); p[2] = DW'(pos_z);
      c[0] = DW'(cam_x); c[1] = DW'(cam_y); c[2] = DW'(cam_z);
      for (int i = 0; i < 3; i++) begin
         s       = p[i] - c[i];
         d_in[i] = s[DW-1] ? DW'(-s) : DW'(s);
      end
   end

   // squares, with far points flagged before the multiply
   always_comb begin
      logic [EW-1:0] e;
      far1_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         e        = EW'(d_ff[i]);
         far1_in  = far1_in | (|e[EW-1:DIST_BITS]);
         sq_in[i] = SQW'(e[DIST_BITS-1:0]) * SQW'(e[DIST_BITS-1:0]);
      end
      sum_in = (SQW+2)'(sq_ff[0]) + (SQW+2)'(sq_ff[1]) + (SQW+2)'(sq_ff[2]);
   end

   // digit by digit square root, two root bits a stage
   always_comb begin
      logic [RW+1:0]        t;
      logic [RW+1:0]        trial;
      logic [DIST_BITS-1:0] q;
      logic [SQW-1:0]       x;
      for (int s = 0; s < SQ_STAGES; s++) begin
         t = '0;
         q = root_ff[s];
         x = x_ff[s];
         rem_in[s] = rem_ff[s];
         for (int j = 0; j < SQ_STEPS; j++) begin
            t     = {rem_in[s], x[SQW-1 -: 2]};
            trial = {2'b00, q, 2'b01};
            if (t >= trial) begin
               t = t - trial;
               q = {q[DIST_BITS-2:0], 1'b1};
            end else begin
               q = {q[DIST_BITS-2:0], 1'b0};
            end
            rem_in[s] = t[RW-1:0];
            x         = {x[SQW-3:0], 2'b00};
         end
         root_in[s] = q;
         x_in[s]    = x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) v_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0] <= in_side;
         far_ff[0]  <= 1'b0;
         for (int i = 0; i < 3; i++) d_ff[i] <= d_in[i];
      end
      if (rdy[1]) begin
         side_ff[1] <= side_ff[0];
         far_ff[1]  <= far1_in;
         for (int i = 0; i < 3; i++) sq_ff[i] <= sq_in[i];
      end
      if (rdy[2]) begin
         side_ff[2] <= side_ff[1];
         far_ff[2]  <= far_ff[1] | (|sum_in[SQW+1:SQW]);
         x_ff[0]    <= sum_in[SQW-1:0];
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
      for (int s = 0; s < SQ_STAGES; s++) begin
         if (rdy[3+s]) begin
            side_ff[3+s] <= side_ff[2+s];
            far_ff[3+s]  <= far_ff[2+s];
            rem_ff[s+1]  <= rem_in[s];
            root_ff[s+1] <= root_in[s];
            x_ff[s+1]    <= x_in[s];
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_dist  = root_ff[SQ_STAGES];
   assign out_far   = far_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule
`default_nettype wire

FILE: hdl/ldf_factor.sv
`default_nettype none
module ldf_factor #(
   parameter int SIDE_WIDTH = 25
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  ldf_pkg::dist_type        in_dist,
   input  wire                      in_far,
   input  wire  [SIDE_WIDTH-1:0]    in_side,
   input  ldf_pkg::dist_type        fog_start,
   input  ldf_pkg::dist_type        fog_end,
   output logic                     out_valid,
   input  wire                      out_ready,
   output ldf_pkg::factor_type      out_factor,
   output logic [SIDE_WIDTH-1:0]    out_side
);
   import ldf_pkg::*;

   localparam int NST = 1 + DIV_STAGES;
   localparam int RW  = DIST_BITS + 1;

   logic                  v_ff    [NST];
   logic [SIDE_WIDTH-1:0] side_ff [NST];
   logic                  zero_ff [NST];
   logic                  one_ff  [NST];
   logic                  rdy     [NST+1];

   logic [RW-1:0]         rem_ff  [DIV_STAGES+1];
   logic [FRAC_BITS-1:0]  quo_ff  [DIV_STAGES+1];
   logic [RW-1:0]         rem_in  [DIV_STAGES];
   logic [FRAC_BITS-1:0]  quo_in  [DIV_STAGES];

   dist_type span;
   dist_type num;
   logic     zero_in;
   logic     one_in;

   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   // span never below one lsb
   assign span    = (fog_end > fog_start) ? dist_type'(fog_end - fog_start) : dist_type'(1);
   assign zero_in = in_far || (in_dist >= fog_end);
   assign num     = dist_type'(fog_end - in_dist);
   assign one_in  = !zero_in && (num >= span);

   // restoring division, two quotient bits a stage
   always_comb begin
      logic [RW-1:0]        r;
      logic [FRAC_BITS-1:0] q;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = rem_ff[s];
         q = quo_ff[s];
         for (int j = 0; j < DIV_STEPS; j++) begin
            r = {r[RW-2:0], 1'b0};
            if (r >= RW'(span)) begin
               r = r - RW'(span);
               q = {q[FRAC_BITS-2:0], 1'b1};
            end else begin
               q = {q[FRAC_BITS-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) v_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0] <= in_side;
         zero_ff[0] <= zero_in;
         one_ff[0]  <= one_in;
         rem_ff[0]  <= RW'(num);
         quo_ff[0]  <= '0;
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (rdy[1+s]) begin
            side_ff[1+s] <= side_ff[s];
            zero_ff[1+s] <= zero_ff[s];
            one_ff[1+s]  <= one_ff[s];
            rem_ff[s+1]  <= rem_in[s];
            quo_ff[s+1]  <= quo_in[s];
         end
      end
   end

   assign out_valid  = v_ff[NST-1];
   assign out_side   = side_ff[NST-1];
   assign out_factor = one_ff[NST-1]  ? FACTOR_ONE :
                       zero_ff[NST-1] ? factor_type'(0) :
                       factor_type'(quo_ff[DIV_STAGES]);

endmodule
`default_nettype wire

FILE: hdl/ldf_blend.sv
`default_nettype none
module ldf_blend #(
   parameter int COLOR_WIDTH = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  ldf_pkg::factor_type          in_factor,
   input  wire                          in_bypass,
   input  wire  [3*COLOR_WIDTH-1:0]     in_color,
   input  wire  [3*COLOR_WIDTH-1:0]     fog_color,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [3*COLOR_WIDTH-1:0]     out_color
);
   import ldf_pkg::*;

   localparam int CW = COLOR_WIDTH;
   localparam int PW = CW + 1 + FACTOR_BITS + 1;
   localparam int VW = CW + FRAC_BITS + 4;

   logic                 v0_ff;
   logic                 v1_ff;
   logic                 bypass_ff;
   logic [CW-1:0]        c_ff    [3];
   logic [CW-1:0]        fog_ff  [3];
   logic signed [PW-1:0] prod_ff [3];
   logic signed [PW-1:0] prod_in [3];
   logic [3*CW-1:0]      out_ff;
   logic [3*CW-1:0]      out_in;
   logic                 rdy0;
   logic                 rdy1;

   assign rdy1     = !v1_ff || out_ready;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   // signed colour difference times factor
   always_comb begin
      logic signed [CW:0]          d;
      logic signed [FACTOR_BITS:0] f;
      f = $signed({1'b0, in_factor});
      for (int i = 0; i < 3; i++) begin
         d = $signed({1'b0, in_color[i*CW +: CW]}) - $signed({1'b0, fog_color[i*CW +: CW]});
         prod_in[i] = PW'(d) * PW'(f);
      end
   end

   // add fog back, round half up, saturate; bypass passes the colour through
   always_comb begin
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] r;
      for (int i = 0; i < 3; i++) begin
         v = $signed(VW'({fog_ff[i], {FRAC_BITS{1'b0}}})) + VW'(prod_ff[i])
           + $signed(VW'(1) <<< (FRAC_BITS - 1));
         r = v >>> FRAC_BITS;
         if (bypass_ff) begin
            out_in[i*CW +: CW] = c_ff[i];
         end else if (r < 0) begin
            out_in[i*CW +: CW] = '0;
         end else if (r > $signed(VW'({CW{1'b1}}))) begin
            out_in[i*CW +: CW] = '1;
         end else begin
            out_in[i*CW +: CW] = r[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         bypass_ff <= in_bypass;
         for (int i = 0; i < 3; i++) begin
            c_ff[i]    <= in_color[i*CW +: CW];
            fog_ff[i]  <= fog_color[i*CW +: CW];
            prod_ff[i] <= prod_in[i];
         end
      end
      if (rdy1) out_ff <= out_in;
   end

   assign out_valid = v1_ff;
   assign out_color = out_ff;

endmodule
`default_nettype wire

FILE: hdl/linear_distance_fog.sv
// sections: distance, then fog factor, then blend, from input transfer to result
// throughput: one item per cycle unless stalled; every stage advances while the next
// has room, so a stall on the result side only backs up once the pipeline is full
// reset: synchronous, clears all valid bits and restores the control registers
// (fog off, start 0, end all ones, fog colour black, camera at the origin)
`default_nettype none
`include "assert_macros.svh"
module linear_distance_fog #(
   parameter  int COORD_WIDTH = 24,
   parameter  int COLOR_WIDTH = 8,
   localparam int CW3         = 3 * COLOR_WIDTH,
   localparam int CSR_WIDTH   = (CW3 > COORD_WIDTH) ?
                                ((CW3 > ldf_pkg::DIST_BITS) ? CW3 : ldf_pkg::DIST_BITS) :
                                ((COORD_WIDTH > ldf_pkg::DIST_BITS) ? COORD_WIDTH :
                                 ldf_pkg::DIST_BITS)
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // configuration writes
   input  wire                                   csr_write_enable,
   input  wire  [ldf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [CSR_WIDTH-1:0]                  csr_write_data,
   // input items
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [COORD_WIDTH-1:0]         req_pos_x,
   input  wire  signed [COORD_WIDTH-1:0]         req_pos_y,
   input  wire  signed [COORD_WIDTH-1:0]         req_pos_z,
   input  wire  [COLOR_WIDTH-1:0]                req_red_in,
   input  wire  [COLOR_WIDTH-1:0]                req_green_in,
   input  wire  [COLOR_WIDTH-1:0]                req_blue_in,
   // results
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [COLOR_WIDTH-1:0]                rsp_red_out,
   output logic [COLOR_WIDTH-1:0]                rsp_green_out,
   output logic [COLOR_WIDTH-1:0]                rsp_blue_out
);
   import ldf_pkg::*;

   localparam int SIDE_WIDTH = CW3 + 1;

   // control registers
   logic                          fog_enable_ff;
   dist_type                      fog_start_ff;
   dist_type                      fog_end_ff;
   logic [CW3-1:0]                fog_color_ff;
   logic signed [COORD_WIDTH-1:0] camera_x_ff;
   logic signed [COORD_WIDTH-1:0] camera_y_ff;
   logic signed [COORD_WIDTH-1:0] camera_z_ff;

   // handshakes between the three sections
   logic                  req_ready;
   logic                  dist_valid;
   logic                  dist_ready;
   dist_type              dist_value;
   logic                  dist_far;
   logic [SIDE_WIDTH-1:0] dist_side;
   logic                  fac_valid;
   logic                  fac_ready;
   factor_type            fac_value;
   logic [SIDE_WIDTH-1:0] fac_side;
   logic [CW3-1:0]        rsp_color;
   logic [SIDE_WIDTH-1:0] req_side;

   // register writes; unknown indexes fall through and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         fog_enable_ff <= 1'b0;
         fog_start_ff  <= '0;
         fog_end_ff    <= '1;
         fog_color_ff  <= '0;
         camera_x_ff   <= '0;
         camera_y_ff   <= '0;
         camera_z_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FOG_ENABLE: fog_enable_ff <= csr_write_data[0];
            CSR_FOG_START:  fog_start_ff  <= csr_write_data[DIST_BITS-1:0];
            CSR_FOG_END:    fog_end_ff    <= csr_write_data[DIST_BITS-1:0];
            CSR_FOG_COLOR:  fog_color_ff  <= csr_write_data[CW3-1:0];
            CSR_CAMERA_X:   camera_x_ff   <= csr_write_data[COORD_WIDTH-1:0];
            CSR_CAMERA_Y:   camera_y_ff   <= csr_write_data[COORD_WIDTH-1:0];
            CSR_CAMERA_Z:   camera_z_ff   <= csr_write_data[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // colour and the bypass decision ride alongside the arithmetic
   assign req_side  = {!fog_enable_ff, req_red_in, req_green_in, req_blue_in};
   assign req_stall = !req_ready;

   // distance: differences, squares, sum, then the pipelined root
   ldf_dist #(
      .COORD_WIDTH (COORD_WIDTH),
      .SIDE_WIDTH  (SIDE_WIDTH)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .cam_x     (camera_x_ff),
      .cam_y     (camera_y_ff),
      .cam_z     (camera_z_ff),
      .in_side   (req_side),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_dist  (dist_value),
      .out_far   (dist_far),
      .out_side  (dist_side)
   );

   // fog factor: clamp tests, then pipelined division by the span
   ldf_factor #(
      .SIDE_WIDTH (SIDE_WIDTH)
   ) u_factor (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dist_valid),
      .in_ready   (dist_ready),
      .in_dist    (dist_value),
      .in_far     (dist_far),
      .in_side    (dist_side),
      .fog_start  (fog_start_ff),
      .fog_end    (fog_end_ff),
      .out_valid  (fac_valid),
      .out_ready  (fac_ready),
      .out_factor (fac_value),
      .out_side   (fac_side)
   );

   // per channel blend into the result register
   ldf_blend #(
      .COLOR_WIDTH (COLOR_WIDTH)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fac_valid),
      .in_ready  (fac_ready),
      .in_factor (fac_value),
      .in_bypass (fac_side[CW3]),
      .in_color  (fac_side[CW3-1:0]),
      .fog_color (fog_color_ff),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_color (rsp_color)
   );

   assign rsp_red_out   = rsp_color[2*COLOR_WIDTH +: COLOR_WIDTH];
   assign rsp_green_out = rsp_color[COLOR_WIDTH +: COLOR_WIDTH];
   assign rsp_blue_out  = rsp_color[0 +: COLOR_WIDTH];

   // an empty result register means every stage can move
   `ASSERT_IMPLIES(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)
   // factor never exceeds one
   `ASSERT_IMPLIES(a_factor_range, clock, reset, fac_valid, fac_value <= FACTOR_ONE)
   // reset flushes every item in flight
   `ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)

endmodule
`default_nettype wire
